// ----- hw/rtl/nms_pkg.sv -----
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types and constants of the box suppression block.
// ----------------------------------------------------------------------------
package nms_pkg;

	localparam int PIPE_DEPTH = 4;
	localparam logic [8:0] LABEL_REMOVED = 9'h1FF;
	localparam logic [15:0] THR_RESET = 16'd45875;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_MIN_AREA = 1'b1;

	typedef struct packed {
		logic [15:0] x_min;
		logic [15:0] y_min;
		logic [15:0] x_max;
		logic [15:0] y_max;
		logic [15:0] score;
		logic [8:0] label;
	} box_t;

	typedef struct packed {
		logic valid;
		logic removed;
		box_t box;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/nms_cell.sv -----
// ----------------------------------------------------------------------------
// nms_cell
// One slot of the sorted box chain: insertion by score and left shift.
// ----------------------------------------------------------------------------
module nms_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  nms_pkg::cell_ctl_t ctl,
	input  nms_pkg::entry_t  new_ent,
	input  nms_pkg::entry_t  left_ent,
	input  logic             left_gt,
	input  nms_pkg::entry_t  right_ent,
	output nms_pkg::entry_t  ent,
	output logic             gt
);
	import nms_pkg::*;

	entry_t ent_q;

	assign ent = ent_q;
	assign gt = !ent_q.valid || (new_ent.box.score > ent_q.box.score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.load) begin
			if (left_gt) begin
				ent_q <= left_ent;
			end else if (gt) begin
				ent_q <= new_ent;
			end
		end else if (ctl.shift) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ----- hw/rtl/nms_ovl_pipe.sv -----
// ----------------------------------------------------------------------------
// nms_ovl_pipe
// Four-stage overlap test of a passing box against the reference box.
// ----------------------------------------------------------------------------
module nms_ovl_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  nms_pkg::box_t   ref_box,
	input  nms_pkg::entry_t in_ent,
	input  logic [15:0]     thr,
	input  logic            min_mode,
	output nms_pkg::entry_t out_ent
);
	import nms_pkg::*;

	entry_t ent_s1, ent_s2, ent_s3, ent_s4;
	logic signed [16:0] iw_s1, ih_s1, wa_s1, ha_s1, wb_s1, hb_s1;
	logic [31:0] inter_s2, inter_s3;
	logic signed [33:0] sa_s2, sb_s2;
	logic signed [34:0] den_s3;

	logic [15:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [34:0] den_c;
	logic [49:0] lhs_c, rhs_c;
	logic above_c;

	always_comb begin
		lo_x = (ref_box.x_min > in_ent.box.x_min) ? ref_box.x_min : in_ent.box.x_min;
		hi_x = (ref_box.x_max < in_ent.box.x_max) ? ref_box.x_max : in_ent.box.x_max;
		lo_y = (ref_box.y_min > in_ent.box.y_min) ? ref_box.y_min : in_ent.box.y_min;
		hi_y = (ref_box.y_max < in_ent.box.y_max) ? ref_box.y_max : in_ent.box.y_max;
		if (min_mode) begin
			den_c = (sa_s2 < sb_s2) ? 35'(sa_s2) : 35'(sb_s2);
		end else begin
			den_c = 35'(sa_s2) + 35'(sb_s2) - $signed({3'b000, inter_s2});
		end
		lhs_c = {2'b00, inter_s3, 16'h0000};
		rhs_c = thr * den_s3[33:0];
		above_c = (den_s3 > 35'sd0) && (lhs_c > rhs_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_s1 <= '0;
			ent_s2 <= '0;
			ent_s3 <= '0;
			ent_s4 <= '0;
		end else if (en) begin
			ent_s1 <= in_ent;
			ent_s2 <= ent_s1;
			ent_s3 <= ent_s2;
			ent_s4 <= '{valid: ent_s3.valid,
				removed: ent_s3.removed | (ent_s3.valid & above_c),
				box: ent_s3.box};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iw_s1 <= $signed({1'b0, hi_x}) - $signed({1'b0, lo_x});
			ih_s1 <= $signed({1'b0, hi_y}) - $signed({1'b0, lo_y});
			wa_s1 <= $signed({1'b0, ref_box.x_max}) - $signed({1'b0, ref_box.x_min});
			ha_s1 <= $signed({1'b0, ref_box.y_max}) - $signed({1'b0, ref_box.y_min});
			wb_s1 <= $signed({1'b0, in_ent.box.x_max}) - $signed({1'b0, in_ent.box.x_min});
			hb_s1 <= $signed({1'b0, in_ent.box.y_max}) - $signed({1'b0, in_ent.box.y_min});
			inter_s2 <= (iw_s1 > 17'sd0 && ih_s1 > 17'sd0) ? iw_s1[15:0] * ih_s1[15:0] : 32'd0;
			sa_s2 <= wa_s1 * ha_s1;
			sb_s2 <= wb_s1 * hb_s1;
			inter_s3 <= inter_s2;
			den_s3 <= den_c;
		end
	end

	assign out_ent = ent_s4;

endmodule

// ----- hw/rtl/box_nms_suppress.sv -----
// ----------------------------------------------------------------------------
// box_nms_suppress
// Greedy non-maximum suppression over a chain of box cells.
// ----------------------------------------------------------------------------
// Boxes load one per cycle and are placed into score order as they arrive. After
// the last box, busy stays high while each surviving box is reported and the
// whole chain is circulated once through the four-stage overlap unit per
// survivor; boxes already removed are shifted out, and a closing step ends the
// set. Results appear one cycle wide on result_valid and cannot be held off.
module box_nms_suppress #(
	parameter int MAX_BOXES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] x_min,
	input  logic [15:0] y_min,
	input  logic [15:0] x_max,
	input  logic [15:0] y_max,
	input  logic [15:0] score,
	input  logic signed [8:0] class_label,
	input  logic        last_box,
	output logic        result_valid,
	output logic [15:0] out_x_min,
	output logic [15:0] out_y_min,
	output logic [15:0] out_x_max,
	output logic [15:0] out_y_max,
	output logic [15:0] out_score,
	output logic [7:0]  out_label,
	output logic        none_left,
	output logic        dropped_boxes,
	output logic        last_result
);
	import nms_pkg::*;

	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int RING = MAX_BOXES + PIPE_DEPTH;
	localparam int PASS_W = $clog2(RING);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HEAD = 3'b010,
		ST_PASS = 3'b100
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [PASS_W-1:0] pass_q;
	logic ovf_q, pend_valid_q;
	box_t ref_q, pend_q;
	logic [15:0] thr_q;
	logic mode_q;

	entry_t ent [MAX_BOXES];
	entry_t left_ent [MAX_BOXES];
	entry_t right_ent [MAX_BOXES];
	logic gt [MAX_BOXES];
	logic left_gt [MAX_BOXES];
	entry_t new_ent, shift_in, pipe_out;
	cell_ctl_t cell_ctl;
	logic accept;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		new_ent.valid = 1'b1;
		new_ent.removed = (class_label == LABEL_REMOVED);
		new_ent.box = '{x_min: x_min, y_min: y_min, x_max: x_max, y_max: y_max,
			score: score, label: class_label};
		cell_ctl.load = accept && (count_q < CNT_W'(MAX_BOXES));
		cell_ctl.shift = ((state_q == ST_HEAD) && ent[0].valid) || (state_q == ST_PASS);
		shift_in = (state_q == ST_PASS) ? pipe_out : '0;
		for (int i = 0; i < MAX_BOXES; i++) begin
			left_ent[i] = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
			left_gt[i] = (i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1];
			right_ent[i] = (i == MAX_BOXES - 1) ? shift_in
				: ent[(i == MAX_BOXES - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
		nms_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.new_ent   (new_ent),
			.left_ent  (left_ent[g]),
			.left_gt   (left_gt[g]),
			.right_ent (right_ent[g]),
			.ent       (ent[g]),
			.gt        (gt[g])
		);
	end

	nms_ovl_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (state_q == ST_PASS),
		.ref_box  (ref_q),
		.in_ent   (ent[0]),
		.thr      (thr_q),
		.min_mode (mode_q),
		.out_ent  (pipe_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q <= cfg_data;
				CFG_MIN_AREA: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pass_q <= '0;
			ovf_q <= 1'b0;
			pend_valid_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cell_ctl.load) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_box) begin
							pend_valid_q <= 1'b0;
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					if (!ent[0].valid) begin
						result_valid <= 1'b1;
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end else if (!ent[0].removed) begin
						result_valid <= pend_valid_q;
						pend_valid_q <= 1'b1;
						pass_q <= PASS_W'(RING - 1);
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					pass_q <= pass_q - PASS_W'(1);
					if (pass_q == '0) begin
						state_q <= ST_HEAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD) begin
			if (!ent[0].valid) begin
				out_x_min <= pend_valid_q ? pend_q.x_min : '0;
				out_y_min <= pend_valid_q ? pend_q.y_min : '0;
				out_x_max <= pend_valid_q ? pend_q.x_max : '0;
				out_y_max <= pend_valid_q ? pend_q.y_max : '0;
				out_score <= pend_valid_q ? pend_q.score : '0;
				out_label <= pend_valid_q ? pend_q.label[7:0] : '0;
				none_left <= !pend_valid_q;
				dropped_boxes <= ovf_q;
				last_result <= 1'b1;
			end else if (!ent[0].removed) begin
				ref_q <= ent[0].box;
				pend_q <= ent[0].box;
				out_x_min <= pend_q.x_min;
				out_y_min <= pend_q.y_min;
				out_x_max <= pend_q.x_max;
				out_y_max <= pend_q.y_max;
				out_score <= pend_q.score;
				out_label <= pend_q.label[7:0];
				none_left <= 1'b0;
				dropped_boxes <= ovf_q;
				last_result <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/nms_checker.sv -----
// ----------------------------------------------------------------------------
// nms_checker
// Port-level checks of the box suppression block, bound to the top level.
// ----------------------------------------------------------------------------
module nms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last_box,
	input logic        result_valid,
	input logic        none_left,
	input logic        last_result,
	input logic [15:0] out_score,
	input logic [7:0]  out_label
);

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && none_left |-> last_result)
		else $error("Empty set result is not marked last.");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && none_left |-> out_score == 16'd0 && out_label == 8'd0)
		else $error("Empty set result carries data.");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |=> !result_valid)
		else $error("Result follows the last result at once.");

	a_last_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_box |=> busy)
		else $error("Final request did not start suppression.");

endmodule

bind box_nms_suppress nms_checker u_nms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_box     (last_box),
	.result_valid (result_valid),
	.none_left    (none_left),
	.last_result  (last_result),
	.out_score    (out_score),
	.out_label    (out_label)
);

// ----- tb/box_nms_suppress_test.sv -----
// ----------------------------------------------------------------------------
// box_nms_suppress_test
// Self-checking testbench of the greedy box suppression block. Sets of boxes
// are sent as requests, first from a table of directed rows and then at
// random, under several threshold and area-mode settings. A predictor sorts
// each set by score, suppresses overlapping boxes and queues the expected
// survivors, which are compared field by field with every result strobe.
// ----------------------------------------------------------------------------
module box_nms_suppress_test;
	import nms_pkg::*;

	localparam int CAP = 64;

	typedef struct packed {
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic [15:0] sc;
		logic [7:0] lbl;
		logic none;
		logic drop;
		logic fin;
	} survivor_t;

	typedef struct {
		logic [15:0] x0, y0, x1, y1, sc;
		logic [8:0] lbl;
		logic fin;
		logic chk;
		survivor_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic [15:0] x_min = '0, y_min = '0, x_max = '0, y_max = '0, score = '0;
	logic signed [8:0] class_label = '0;
	logic last_box = 1'b0;
	logic result_valid;
	logic [15:0] out_x_min, out_y_min, out_x_max, out_y_max, out_score;
	logic [7:0] out_label;
	logic none_left, dropped_boxes, last_result;

	box_nms_suppress uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state.
	box_t set_boxes[$];
	logic set_overflow;
	logic [15:0] thr;
	logic min_mode;
	survivor_t survivors_due[$];
	int errors = 0;

	function automatic bit suppresses(box_t a, box_t b);
		longint iw, ih, inter, sa, sb, den;
		iw = (a.x_max < b.x_max ? a.x_max : b.x_max) - (a.x_min > b.x_min ? a.x_min : b.x_min);
		ih = (a.y_max < b.y_max ? a.y_max : b.y_max) - (a.y_min > b.y_min ? a.y_min : b.y_min);
		inter = (iw > 0 && ih > 0) ? iw * ih : 0;
		sa = (longint'(a.x_max) - a.x_min) * (longint'(a.y_max) - a.y_min);
		sb = (longint'(b.x_max) - b.x_min) * (longint'(b.y_max) - b.y_min);
		den = min_mode ? (sa < sb ? sa : sb) : sa + sb - inter;
		if (den <= 0)
			return 0;
		return inter * 65536 > longint'(thr) * den;
	endfunction

	task automatic predict_box(box_t b, logic fin);
		box_t sorted[$];
		bit gone[$];
		survivor_t s;
		int k, n;
		if (set_boxes.size() < CAP)
			set_boxes.insert(set_boxes.size(), b);
		else
			set_overflow = 1'b1;
		if (!fin)
			return;
		foreach (set_boxes[i]) begin
			k = 0;
			while (k < sorted.size() && sorted[k].score >= set_boxes[i].score)
				k++;
			sorted.insert(k, set_boxes[i]);
		end
		foreach (sorted[i])
			gone.insert(gone.size(), sorted[i].label == LABEL_REMOVED);
		for (int i = 0; i < sorted.size(); i++)
			if (!gone[i])
				for (int j = i + 1; j < sorted.size(); j++)
					if (!gone[j] && suppresses(sorted[i], sorted[j]))
						gone[j] = 1;
		n = 0;
		foreach (sorted[i])
			if (!gone[i]) begin
				s = '{sorted[i].x_min, sorted[i].y_min, sorted[i].x_max, sorted[i].y_max,
					sorted[i].score, sorted[i].label[7:0], 1'b0, set_overflow, 1'b0};
				survivors_due.insert(survivors_due.size(), s);
				n++;
			end
		if (n == 0) begin
			s = '0;
			s.none = 1'b1;
			s.drop = set_overflow;
			survivors_due.insert(survivors_due.size(), s);
		end
		survivors_due[$].fin = 1'b1;
		set_boxes.delete();
		set_overflow = 1'b0;
	endtask

	// Result checker.
	survivor_t typed_due[$];
	always @(posedge clk) begin
		survivor_t got, want;
		if (arst_n && result_valid) begin
			got = '{out_x_min, out_y_min, out_x_max, out_y_max, out_score, out_label,
				none_left, dropped_boxes, last_result};
			if (survivors_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = survivors_due.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h got %h", want, got);
				end
				if (typed_due.size() != 0) begin
					want = typed_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("table mismatch: expected %h got %h", want, got);
					end
				end
			end
		end
	end

	task automatic write_reg(logic idx, logic [15:0] val);
		start <= 1'b0;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_THRESHOLD)
			thr = val;
		else
			min_mode = val[0];
	endtask

	// The request line stays high after an accepted request so that a request
	// with no gap follows at once; it drops only for a gap, a register write or a drain.
	task automatic send_box(box_t b, logic fin);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		{x_min, y_min, x_max, y_max, score, class_label} <= b;
		last_box <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_box(b, fin);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (survivors_due.size() != 0)
			@(posedge clk);
		repeat (CAP * (CAP + 6) + 20) @(posedge clk);
	endtask

	function automatic box_t rand_box(bit tidy);
		box_t b;
		logic [15:0] w, h;
		if (tidy) begin
			b.x_min = 16'($urandom_range(0, 400));
			b.y_min = 16'($urandom_range(0, 400));
			w = 16'($urandom_range(1, 200));
			h = 16'($urandom_range(1, 200));
			b.x_max = b.x_min + w;
			b.y_max = b.y_min + h;
			if ($urandom_range(0, 15) == 0)
				b.x_min = 16'(16'hFFFF - $urandom_range(0, 300));
		end else begin
			b.x_min = 16'($urandom);
			b.y_min = 16'($urandom);
			b.x_max = 16'($urandom);
			b.y_max = 16'($urandom);
		end
		b.score = $urandom_range(0, 7) == 0 ? 16'h8000 : 16'($urandom);
		case ($urandom_range(0, 9))
			0: b.label = LABEL_REMOVED;
			1: b.label = 9'($urandom_range(256, 510));
			default: b.label = 9'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	row_t plan[$];
	box_t b;
	int sets;
	int n_boxes;

	initial begin
		plan = '{
			'{16'd0, 16'd0, 16'd16, 16'd16, 16'hFFFF, 9'd255, 1'b1, 1'b1,
				'{16'd0, 16'd0, 16'd16, 16'd16, 16'hFFFF, 8'd255, 1'b0, 1'b0, 1'b1}},
			'{16'd0, 16'd0, 16'd16, 16'd16, 16'd0, LABEL_REMOVED, 1'b1, 1'b1,
				'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 1'b1, 1'b0, 1'b1}},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd5, 9'h100, 1'b1, 1'b1,
				'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd5, 8'd0, 1'b0, 1'b0, 1'b1}},
			'{16'd0, 16'd0, 16'd100, 16'd100, 16'd900, 9'd3, 1'b0, 1'b0, '0},
			'{16'd0, 16'd0, 16'd100, 16'd100, 16'd900, 9'd4, 1'b0, 1'b0, '0},
			'{16'd10, 16'd10, 16'd100, 16'd100, 16'd1000, 9'd5, 1'b1, 1'b0, '0},
			'{16'd100, 16'd0, 16'd0, 16'd100, 16'd7, 9'h1FE, 1'b0, 1'b0, '0},
			'{16'd0, 16'd0, 16'd0, 16'd0, 16'd7, 9'd1, 1'b0, 1'b0, '0},
			'{16'd0, 16'd0, 16'd50, 16'd50, 16'd7, 9'd2, 1'b0, 1'b0, '0},
			'{16'd50, 16'd50, 16'd90, 16'd90, 16'd8, 9'd2, 1'b0, 1'b0, '0},
			'{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd9, 9'd0, 1'b1, 1'b0, '0}
		};
		thr = THR_RESET;
		min_mode = 1'b0;
		set_overflow = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].chk)
				typed_due.insert(typed_due.size(), plan[i].want);
			send_box('{plan[i].x0, plan[i].y0, plan[i].x1, plan[i].y1, plan[i].sc,
				plan[i].lbl}, plan[i].fin);
		end
		drain();
		write_reg(CFG_MIN_AREA, 16'd1);
		write_reg(CFG_THRESHOLD, 16'd0);
		foreach (plan[i])
			send_box('{plan[i].x0, plan[i].y0, plan[i].x1, plan[i].y1, plan[i].sc,
				plan[i].lbl}, plan[i].fin);
		drain();

		// Overflow set: one past capacity, the extra box is the last one.
		write_reg(CFG_THRESHOLD, 16'hFFFF);
		for (int i = 0; i <= CAP; i++)
			send_box(rand_box(1), i == CAP);
		drain();

		sets = 0;
		n_boxes = 0;
		while (n_boxes < 20 || survivors_due.size() != 0) begin
			if (n_boxes >= 20)
				@(posedge clk);
			else begin
				case (sets % 4)
					0: write_reg(CFG_THRESHOLD, 16'($urandom));
					1: write_reg(CFG_MIN_AREA, 16'($urandom));
					2: write_reg(CFG_THRESHOLD, 16'h0000);
					default: write_reg(CFG_THRESHOLD, 16'hFFFF);
				endcase
				for (int k = $urandom_range(1, 8); k > 0; k--) begin
					send_box(rand_box($urandom_range(0, 4) != 0), k == 1);
					n_boxes++;
				end
				sets++;
				drain();
			end
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && survivors_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
